[hdl/teactr_pkg.sv]
package teactr_pkg;

    localparam int BLOCK_W        = 64;
    localparam int WORD_W         = 32;
    localparam int ROUNDS_DEFAULT = 1024;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

    typedef struct packed {
        logic [WORD_W-1:0] k3;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k0;
    } key_t;

    // One queued job: the data block and the block to be enciphered.
    typedef struct packed {
        logic [BLOCK_W-1:0] data_block;
        logic [BLOCK_W-1:0] ctr_block;
    } job_t;

    // Front-to-queue push.
    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

    // Queue-to-back handshake.
    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    // TEA mixing term: ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb)
    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb,
        input logic [WORD_W-1:0] sum
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

[hdl/teactr_if.sv]
interface teactr_in_if;
    logic                            valid;
    logic                            ready;
    logic [teactr_pkg::BLOCK_W-1:0]  data_block;
    logic                            first_block;

    modport source (output valid, output data_block, output first_block, input ready);
    modport sink   (input valid, input data_block, input first_block, output ready);
endinterface

interface teactr_out_if;
    logic                            valid;
    logic                            ready;
    logic [teactr_pkg::BLOCK_W-1:0]  result_block;

    modport source (output valid, output result_block, input ready);
    modport sink   (input valid, input result_block, output ready);
endinterface

[hdl/teactr_front.sv]
module teactr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    teactr_in_if.sink                      data_chan,
    input  logic [teactr_pkg::BLOCK_W-1:0] counter_nonce,
    input  logic                           queue_full,
    output teactr_pkg::push_t              push_o
);
    import teactr_pkg::*;

    logic [WORD_W-1:0] block_counter_reg;
    logic [WORD_W-1:0] block_counter_next;
    logic [WORD_W-1:0] ctr;
    logic              accept;

    assign data_chan.ready = ~queue_full;
    assign accept          = data_chan.valid & data_chan.ready;

    // first_block restarts at zero; the counter wraps naturally.
    assign ctr                = data_chan.first_block ? '0 : block_counter_reg;
    assign block_counter_next = ctr + WORD_W'(1);

    always_comb
    begin
        push_o.push           = accept;
        push_o.job.data_block = data_chan.data_block;
        push_o.job.ctr_block  = {{(BLOCK_W-WORD_W){1'b0}}, ctr} ^ counter_nonce;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_counter_reg <= '0;
        end
        else if (accept)
        begin
            block_counter_reg <= block_counter_next;
        end
    end

endmodule

[hdl/teactr_queue.sv]
module teactr_queue #(
    parameter int DEPTH = teactr_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  teactr_pkg::push_t push_i,
    input  logic              pop,
    output teactr_pkg::head_t head_o,
    output logic              full
);
    import teactr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full         = (count_reg == CNT_W'(DEPTH));
    assign head_o.valid = (count_reg != '0);
    assign head_o.job   = mem[rd_ptr_reg];
    assign do_pop       = pop & head_o.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_i.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push_i.push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_i.push)
        begin
            mem[wr_ptr_reg] <= push_i.job;
        end
    end

endmodule

[hdl/teactr_back.sv]
module teactr_back #(
    parameter int ROUNDS = teactr_pkg::ROUNDS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  teactr_pkg::key_t  key,
    input  teactr_pkg::head_t head_i,
    output logic              pop,
    teactr_out_if.source      result_chan
);
    import teactr_pkg::*;

    // Stage 0 is the load stage; stages 1..STAGES each do one half round.
    localparam int STAGES = 2 * ROUNDS;

    logic               valid_reg [STAGES+1];
    logic [WORD_W-1:0]  v0_reg    [STAGES+1];
    logic [WORD_W-1:0]  v1_reg    [STAGES+1];
    logic [BLOCK_W-1:0] data_reg  [STAGES+1];

    logic               res_valid_reg;
    logic [BLOCK_W-1:0] res_reg;
    logic               advance;

    // Whole pipe moves together unless the result register is held.
    assign advance = ~res_valid_reg | result_chan.ready;
    assign pop     = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= head_i.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            v0_reg[0]   <= head_i.job.ctr_block[WORD_W-1:0];
            v1_reg[0]   <= head_i.job.ctr_block[BLOCK_W-1:WORD_W];
            data_reg[0] <= head_i.job.data_block;
        end
    end

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        localparam int               S_A  = 2 * r + 1;
        localparam int               S_B  = 2 * r + 2;
        localparam logic [WORD_W-1:0] RSUM =
            WORD_W'(64'(TEA_DELTA) * 64'(r + 1));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[S_A] <= 1'b0;
                valid_reg[S_B] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[S_A] <= valid_reg[S_A-1];
                valid_reg[S_B] <= valid_reg[S_A];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                v0_reg[S_A]   <= v0_reg[S_A-1]
                               + tea_mix(v1_reg[S_A-1], key.k0, key.k1, RSUM);
                v1_reg[S_A]   <= v1_reg[S_A-1];
                data_reg[S_A] <= data_reg[S_A-1];

                v0_reg[S_B]   <= v0_reg[S_A];
                v1_reg[S_B]   <= v1_reg[S_A]
                               + tea_mix(v0_reg[S_A], key.k2, key.k3, RSUM);
                data_reg[S_B] <= data_reg[S_A];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= data_reg[STAGES] ^ {v1_reg[STAGES], v0_reg[STAGES]};
        end
    end

    assign result_chan.valid        = res_valid_reg;
    assign result_chan.result_block = res_reg;

endmodule

[hdl/tea_counter_mode_stream_cipher.sv]
// Throughput: one block per cycle while the result is not stalled.
// The cipher is a 2*ROUNDS-stage half-round pipeline.
// A stalled result holds the whole pipe; the front queue keeps accepting until it fills.
// Reset (rst_n, async, active low) clears keys, nonce, block counter and all valid flags.
module tea_counter_mode_stream_cipher #(
    parameter int ROUNDS = teactr_pkg::ROUNDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    teactr_in_if.sink   data_chan,
    teactr_out_if.source result_chan,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import teactr_pkg::*;

    // Register map: index = paddr[5:3] (8-byte stride, 64-bit data).
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    key_t               key_reg;
    logic [BLOCK_W-1:0] nonce_reg;
    logic [2:0]         reg_idx;
    logic               wr_en;

    push_t              push;
    head_t              head;
    logic               queue_full;
    logic               pop;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel & penable & pwrite;

    // Writes to unmapped indexes fall through and are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            nonce_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_KEY0:  key_reg.k0 <= pwdata[WORD_W-1:0];
                REG_KEY1:  key_reg.k1 <= pwdata[WORD_W-1:0];
                REG_KEY2:  key_reg.k2 <= pwdata[WORD_W-1:0];
                REG_KEY3:  key_reg.k3 <= pwdata[WORD_W-1:0];
                REG_NONCE: nonce_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY0:  prdata = {{(64-WORD_W){1'b0}}, key_reg.k0};
            REG_KEY1:  prdata = {{(64-WORD_W){1'b0}}, key_reg.k1};
            REG_KEY2:  prdata = {{(64-WORD_W){1'b0}}, key_reg.k2};
            REG_KEY3:  prdata = {{(64-WORD_W){1'b0}}, key_reg.k3};
            REG_NONCE: prdata = nonce_reg;
            default:   prdata = '0;
        endcase
    end

    // ---------------- front: counter resolve, nonce mix ----------------
    // Each transfer takes counter zero on first_block, else the running
    // count; the job carries (counter ^ nonce) as the block to encipher.
    teactr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_chan     (data_chan),
        .counter_nonce (nonce_reg),
        .queue_full    (queue_full),
        .push_o        (push)
    );

    // ---------------- decoupling queue ----------------
    // Lets the front keep taking transfers until the queue fills while the
    // back is held by a stalled result.
    teactr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_i (push),
        .pop    (pop),
        .head_o (head),
        .full   (queue_full)
    );

    // ---------------- back: TEA pipeline and output XOR ----------------
    teactr_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (key_reg),
        .head_i      (head),
        .pop         (pop),
        .result_chan (result_chan)
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

// Bench for the TEA counter-mode cipher. Blocks go in through the data
// channel, and the results are checked in order against an in-bench
// keystream predictor. Keys and nonce are written over APB, and only
// while the pipe is empty.
module tb_top;
    import teactr_pkg::*;

    localparam int ROUNDS_USED  = ROUNDS_DEFAULT;
    // Data transfer to result valid; the final drain wait adds a margin.
    localparam int PIPE_LATENCY = 2 * ROUNDS_USED + 2;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 160;
    localparam int RAND_PHASES  = 6;

    // APB register indexes; byte address is 8*index since the nonce is 64 bits.
    localparam int REG_KEY_ZERO  = 0;
    localparam int REG_KEY_ONE   = 1;
    localparam int REG_KEY_TWO   = 2;
    localparam int REG_KEY_THREE = 3;
    localparam int REG_NONCE     = 4;
    localparam int REG_UNMAPPED  = 5;
    localparam int REG_UNMAPPED2 = 7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [BLOCK_W-1:0] data;
        logic               first;
    } block_item_t;

    // Clock, reset and every DUT input start at known values.
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic [63:0] in_data  = '0;
    logic        in_first = 1'b0;
    logic        out_ready = 1'b1;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [5:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    logic [63:0] prdata;
    logic        pready;

    teactr_in_if  data_if ();
    teactr_out_if result_if ();

    assign data_if.valid       = in_valid;
    assign data_if.data_block  = in_data;
    assign data_if.first_block = in_first;
    assign result_if.ready     = out_ready;

    tea_counter_mode_stream_cipher #(
        .ROUNDS (ROUNDS_USED)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_chan   (data_if),
        .result_chan (result_if),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow of the cipher configuration and the block counter.
    key_t        key_shadow   = '0;
    logic [63:0] nonce_shadow = '0;
    logic [31:0] next_counter = '0;

    block_item_t       pending_blocks[$];
    logic [BLOCK_W-1:0] expected_results[$];
    int                mismatches   = 0;
    int                cycle_count  = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Full TEA encipher of one counter block under the shadow key.
    // v0 is the low word, v1 the high word.
    function automatic logic [63:0] tea_keystream_of(input logic [63:0] ctr_block);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
        v0  = ctr_block[31:0];
        v1  = ctr_block[63:32];
        sum = '0;
        for (int r = 0; r < ROUNDS_USED; r++)
        begin
            sum = sum + TEA_DELTA;
            v0 = v0 + (((v1 << 4) + key_shadow.k0) ^ (v1 + sum) ^ ((v1 >> 5) + key_shadow.k1));
            v1 = v1 + (((v0 << 4) + key_shadow.k2) ^ (v0 + sum) ^ ((v0 >> 5) + key_shadow.k3));
        end
        return {v1, v0};
    endfunction

    // Driver: a new block goes out only once the last one transferred
    // (or nothing was on the bus); the sender idles at random in between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_first <= 1'b0;
        end
        else if (!in_valid || data_if.ready)
        begin
            if (pending_blocks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_blocks[0].data;
                in_first <= pending_blocks[0].first;
                void'(pending_blocks.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: predict on each input transfer, check on each output transfer.
    // Prediction runs first so an expectation is never missing by event order.
    always @(posedge clk)
    begin : monitor
        logic [31:0]       ctr;
        logic [BLOCK_W-1:0] want;
        if (rst_n)
        begin
            if (in_valid && data_if.ready)
            begin
                // First-block flag restarts at zero; the counter wraps at 2^32.
                ctr = in_first ? 32'd0 : next_counter;
                expected_results.push_back(in_data ^ tea_keystream_of({32'd0, ctr} ^ nonce_shadow));
                next_counter = ctr + 32'd1;
            end
            if (result_if.valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, expected none, got %h",
                             $time, result_if.result_block);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_if.result_block !== want)
                    begin
                        $display("%0t: result_block mismatch, expected %h, got %h",
                                 $time, want, result_if.result_block);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 56; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default:       begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    // The shadow follows the register map; unmapped indexes change nothing.
    task automatic cfg_write(input int idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KEY_ZERO:  key_shadow.k0 = value[31:0];
            REG_KEY_ONE:   key_shadow.k1 = value[31:0];
            REG_KEY_TWO:   key_shadow.k2 = value[31:0];
            REG_KEY_THREE: key_shadow.k3 = value[31:0];
            REG_NONCE:     nonce_shadow  = value;
            default:       ;
        endcase
    endtask

    task automatic cfg_all(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3,
                           input logic [63:0] nonce);
        cfg_write(REG_KEY_ZERO, {32'hDEAD_0000, k0});  // upper half must be dropped
        cfg_write(REG_KEY_ONE, {32'd0, k1});
        cfg_write(REG_KEY_TWO, {32'd0, k2});
        cfg_write(REG_KEY_THREE, {32'hFFFF_FFFF, k3});
        cfg_write(REG_NONCE, nonce);
    endtask

    // Wait until every queued block went in and every result came out.
    // Sampled on the falling edge, once the rising-edge updates have settled.
    task automatic wait_drained();
        while (pending_blocks.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_block(input logic [63:0] data, input logic first);
        block_item_t item;
        item.data  = data;
        item.first = first;
        pending_blocks.push_back(item);
    endtask

    function automatic logic [63:0] rand_block();
        case ($urandom_range(0, 15))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        set_idling(IDLE_NONE);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset config (all-zero key and nonce): data extremes,
        // first-block restarts back to back and mid-stream.
        queue_block(64'd0, 1'b1);
        queue_block(64'd0, 1'b0);
        queue_block('1, 1'b0);
        queue_block(64'h5555_5555_5555_5555, 1'b0);
        queue_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_block(64'h0000_0000_FFFF_FFFF, 1'b1);
        queue_block(64'hFFFF_FFFF_0000_0000, 1'b1);
        queue_block(64'h8000_0000_0000_0001, 1'b0);
        queue_block(64'h0123_4567_89AB_CDEF, 1'b0);
        queue_block(64'd0, 1'b1);
        queue_block('1, 1'b0);
        queue_block(64'd0, 1'b0);
        wait_drained();

        // All-ones key and nonce; writes to unmapped addresses must be ignored.
        cfg_all('1, '1, '1, '1, '1);
        cfg_write(REG_UNMAPPED, 64'h1234_5678_9ABC_DEF0);
        cfg_write(REG_UNMAPPED2, '1);
        queue_block(64'd0, 1'b0);
        queue_block(64'd0, 1'b1);
        queue_block('1, 1'b0);
        queue_block(64'h5555_5555_AAAA_AAAA, 1'b0);
        queue_block(64'd0, 1'b1);
        queue_block(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        queue_block(64'd1, 1'b0);
        wait_drained();

        // Random phases: one key/nonce setting each, idling pattern rotates.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: cfg_all($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
                1: cfg_all('0, '0, '0, '0, '1);
                2: cfg_write(REG_NONCE, {$urandom, $urandom});  // nonce only
                3: cfg_all('1, '0, '1, '0, 64'h0000_0000_FFFF_FFFF);
                4: cfg_all($urandom, $urandom, $urandom, $urandom, 64'd0);
                default: cfg_all($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
            endcase
            set_idling(idle_mode_e'(ph % 4));
            // Mostly continuous streams, each opened with a first block,
            // plus a scatter of extra restarts.
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_block(rand_block(), (n == 0) || ($urandom_range(0, 19) == 0));
            wait_drained();
        end

        set_idling(IDLE_NONE);
        repeat (PIPE_LATENCY + 20) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
